>>> design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared widths, command codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned HalfW     = 10;
  localparam int unsigned StretchW  = 16;
  localparam int unsigned BitIdxW   = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // command codes
  localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_START = 3'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ  = 3'd4;

  // status codes reported with done
  localparam logic [StatusW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatusW-1:0] STAT_NACK    = 2'd1;
  localparam logic [StatusW-1:0] STAT_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HALF_PERIOD     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STRETCH_TIMEOUT = 2'd1;

  localparam logic [HalfW-1:0]    HALF_PERIOD_RST     = 10'd5;
  localparam logic [StretchW-1:0] STRETCH_TIMEOUT_RST = 16'd1000;

  // last bit of a byte transfer is the ACK slot
  localparam logic [BitIdxW-1:0] ACK_BIT   = 4'd8;
  localparam logic [BitIdxW-1:0] LAST_BITS = 4'd9;

endpackage

>>> design/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Tick input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface i2cm_in_if
  import i2cm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [ByteW-1:0] data_byte;
  logic             send_ack;
  logic             scl_in;
  logic             sda_in;

  modport source (output valid, cmd, data_byte, send_ack, scl_in, sda_in, input ready);
  modport sink   (input valid, cmd, data_byte, send_ack, scl_in, sda_in, output ready);
endinterface

interface i2cm_out_if
  import i2cm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               scl_pull_low;
  logic               sda_pull_low;
  logic               busy_res;
  logic               done_res;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   read_data;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, status,
                  read_data, input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, status,
                  read_data, output ready);
endinterface

interface i2cm_cfg_if
  import i2cm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain bit sequencer for START, STOP, byte write and byte read.
// ----------------------------------------------------------------------------
// Each input word is one timebase tick carrying the sampled SCL/SDA levels and
// an optional command; it advances the sequencer by one tick and yields exactly
// one result word with the line drives, busy, done, status and last read byte.
// The tick is folded into the state in the cycle it is accepted and its result
// appears in the output register on the next cycle, so a new word is taken
// every cycle while the output side keeps up (throughput one word per clock, each
// result held in the single result register).
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_in_if.sink    in_i,
  i2cm_out_if.source out_o
);

  typedef enum logic [12:0] {
    PH_IDLE  = 13'b0_0000_0000_0001,
    PH_ST_W  = 13'b0_0000_0000_0010,
    PH_ST_D1 = 13'b0_0000_0000_0100,
    PH_ST_D2 = 13'b0_0000_0000_1000,
    PH_ST_D3 = 13'b0_0000_0001_0000,
    PH_SP_D1 = 13'b0_0000_0010_0000,
    PH_SP_W  = 13'b0_0000_0100_0000,
    PH_SP_D2 = 13'b0_0000_1000_0000,
    PH_SP_D3 = 13'b0_0001_0000_0000,
    PH_BIT_L = 13'b0_0010_0000_0000,
    PH_BIT_W = 13'b0_0100_0000_0000,
    PH_BIT_H = 13'b0_1000_0000_0000,
    PH_BIT_E = 13'b1_0000_0000_0000
  } phase_e;

  // configuration
  logic [HalfW-1:0]    half_period_q;
  logic [StretchW-1:0] stretch_to_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic                is_wr_q, is_wr_d;
  logic [BitIdxW-1:0]  bit_idx_q, bit_idx_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic [HalfW-1:0]    half_cnt_q, half_cnt_d;
  logic [StretchW-1:0] stretch_cnt_q, stretch_cnt_d;
  logic                drv_scl_q, drv_scl_d;
  logic                drv_sda_q, drv_sda_d;
  logic                ack_mode_q, ack_mode_d;
  logic [ByteW-1:0]    last_rd_q, last_rd_d;

  // result register
  logic                out_valid_q;
  logic                out_done_q, done_d;
  logic [StatusW-1:0]  out_status_q, status_d;

  logic in_take;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_take     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      stretch_to_q  <= STRETCH_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HALF_PERIOD:     half_period_q <= cfg_i.data[HalfW-1:0];
        REG_STRETCH_TIMEOUT: stretch_to_q  <= cfg_i.data[StretchW-1:0];
        default: ;
      endcase
    end
  end

  // SDA release for the bit about to start: data bit, ACK slot or sampled slot
  function automatic logic bit_release(input logic wr, input logic [BitIdxW-1:0] bi,
                                       input logic [ByteW-1:0] sr, input logic am);
    logic [2:0] pos;
    logic       rd_slot;
    pos     = 3'd7 - bi[2:0];
    rd_slot = wr ? (bi == ACK_BIT) : (bi < ACK_BIT);
    if (rd_slot) begin
      bit_release = 1'b1;
    end else if (wr) begin
      bit_release = sr[pos];
    end else begin
      bit_release = !am;
    end
  endfunction

  logic [HalfW-1:0]    half_inc;
  logic [HalfW-1:0]    half_lim;
  logic                dly_done;
  logic [StretchW-1:0] stretch_inc;
  logic                stretch_hit;
  logic [BitIdxW-1:0]  bit_inc;
  logic                rd_slot;

  assign half_inc    = half_cnt_q + HalfW'(1);
  assign half_lim    = (half_period_q == '0) ? HalfW'(1) : half_period_q;
  assign dly_done    = half_inc >= half_lim;
  assign stretch_inc = stretch_cnt_q + StretchW'(1);
  assign stretch_hit = stretch_inc >= stretch_to_q;
  assign bit_inc     = bit_idx_q + BitIdxW'(1);
  assign rd_slot     = is_wr_q ? (bit_idx_q == ACK_BIT) : (bit_idx_q < ACK_BIT);

  always_comb begin
    phase_d       = phase_q;
    is_wr_d       = is_wr_q;
    bit_idx_d     = bit_idx_q;
    shift_d       = shift_q;
    half_cnt_d    = half_cnt_q;
    stretch_cnt_d = stretch_cnt_q;
    drv_scl_d     = drv_scl_q;
    drv_sda_d     = drv_sda_q;
    ack_mode_d    = ack_mode_q;
    last_rd_d     = last_rd_q;
    done_d        = 1'b0;
    status_d      = STAT_OK;

    case (phase_q)
      PH_IDLE: begin
        half_cnt_d    = '0;
        stretch_cnt_d = '0;
        case (in_i.cmd)
          CMD_START: begin
            drv_scl_d = 1'b0;
            drv_sda_d = 1'b0;
            phase_d   = PH_ST_W;
          end
          CMD_STOP: begin
            drv_sda_d = 1'b1;
            phase_d   = PH_SP_D1;
          end
          CMD_WRITE, CMD_READ: begin
            is_wr_d    = (in_i.cmd == CMD_WRITE);
            bit_idx_d  = '0;
            shift_d    = is_wr_d ? in_i.data_byte : '0;
            ack_mode_d = is_wr_d ? 1'b0 : in_i.send_ack;
            drv_sda_d  = !bit_release(is_wr_d, '0, shift_d, ack_mode_d);
            phase_d    = PH_BIT_L;
          end
          default: ;
        endcase
      end
      PH_ST_W, PH_BIT_W: begin
        if (in_i.scl_in) begin
          stretch_cnt_d = '0;
          half_cnt_d    = '0;
          phase_d       = (phase_q == PH_ST_W) ? PH_ST_D1 : PH_BIT_H;
        end else if (stretch_hit) begin
          stretch_cnt_d = '0;
          half_cnt_d    = '0;
          phase_d       = PH_IDLE;
          done_d        = 1'b1;
          status_d      = STAT_TIMEOUT;
        end else begin
          stretch_cnt_d = stretch_inc;
        end
      end
      PH_SP_W: begin
        // stop carries on past a timeout
        if (in_i.scl_in || stretch_hit) begin
          stretch_cnt_d = '0;
          half_cnt_d    = '0;
          phase_d       = PH_SP_D2;
        end else begin
          stretch_cnt_d = stretch_inc;
        end
      end
      PH_ST_D1, PH_ST_D2, PH_ST_D3, PH_SP_D1, PH_SP_D2, PH_SP_D3, PH_BIT_L,
      PH_BIT_H, PH_BIT_E: begin
        if (!dly_done) begin
          half_cnt_d = half_inc;
        end else begin
          half_cnt_d    = '0;
          stretch_cnt_d = '0;
          case (phase_q)
            PH_ST_D1: begin
              drv_sda_d = 1'b1;
              phase_d   = PH_ST_D2;
            end
            PH_ST_D2: begin
              drv_scl_d = 1'b1;
              phase_d   = PH_ST_D3;
            end
            PH_SP_D1: begin
              drv_scl_d = 1'b0;
              phase_d   = PH_SP_W;
            end
            PH_SP_D2: begin
              drv_sda_d = 1'b0;
              phase_d   = PH_SP_D3;
            end
            PH_BIT_L: begin
              drv_scl_d = 1'b0;
              phase_d   = PH_BIT_W;
            end
            PH_BIT_H: begin
              if (rd_slot) begin
                if (is_wr_q) begin
                  ack_mode_d = in_i.sda_in;
                end else begin
                  shift_d = {shift_q[ByteW-2:0], in_i.sda_in};
                end
              end
              drv_scl_d = 1'b1;
              phase_d   = PH_BIT_E;
            end
            PH_BIT_E: begin
              bit_idx_d = bit_inc;
              if (bit_inc >= LAST_BITS) begin
                if (is_wr_q) begin
                  status_d = ack_mode_q ? STAT_NACK : STAT_OK;
                end else begin
                  last_rd_d = shift_q;
                end
                phase_d = PH_IDLE;
                done_d  = 1'b1;
              end else begin
                drv_sda_d = !bit_release(is_wr_q, bit_inc, shift_q, ack_mode_q);
                phase_d   = PH_BIT_L;
              end
            end
            default: begin
              // start and stop hold times end the command
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end
          endcase
        end
      end
      default: begin
        half_cnt_d    = '0;
        stretch_cnt_d = '0;
        phase_d       = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      is_wr_q       <= 1'b0;
      bit_idx_q     <= '0;
      shift_q       <= '0;
      half_cnt_q    <= '0;
      stretch_cnt_q <= '0;
      drv_scl_q     <= 1'b0;
      drv_sda_q     <= 1'b0;
      ack_mode_q    <= 1'b0;
      last_rd_q     <= '0;
      out_valid_q   <= 1'b0;
      out_done_q    <= 1'b0;
      out_status_q  <= STAT_OK;
    end else if (in_take) begin
      phase_q       <= phase_d;
      is_wr_q       <= is_wr_d;
      bit_idx_q     <= bit_idx_d;
      shift_q       <= shift_d;
      half_cnt_q    <= half_cnt_d;
      stretch_cnt_q <= stretch_cnt_d;
      drv_scl_q     <= drv_scl_d;
      drv_sda_q     <= drv_sda_d;
      ack_mode_q    <= ack_mode_d;
      last_rd_q     <= last_rd_d;
      out_valid_q   <= 1'b1;
      out_done_q    <= done_d;
      out_status_q  <= done_d ? status_d : STAT_OK;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // the live state is the result of the last word taken
  assign out_o.valid        = out_valid_q;
  assign out_o.scl_pull_low = drv_scl_q;
  assign out_o.sda_pull_low = drv_sda_q;
  assign out_o.busy_res     = (phase_q != PH_IDLE);
  assign out_o.done_res     = out_done_q;
  assign out_o.status       = out_status_q;
  assign out_o.read_data    = last_rd_q;

  // a finishing word never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> (phase_q == PH_IDLE))
    else $error("done reported while busy");

  // status is only non-zero alongside done
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_status_q != STAT_OK) |-> out_done_q)
    else $error("status without done");

  // a timeout always leaves SCL released
  a_timeout_scl_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done_q && (out_status_q == STAT_TIMEOUT) |-> !drv_scl_q)
    else $error("timeout with SCL held low");

  // bit counter never runs past LAST_BITS, one beyond the ACK slot
  a_bit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (bit_idx_q <= LAST_BITS))
    else $error("bit index out of range");

endmodule
